FILE: rtl/icoal_pkg.sv
// Shared types and constants for the inflight request coalescer.
// Holds the item structs, result kinds, command and register codes.
// No dependencies.
package icoal_pkg;

   localparam int SLOTS_DEFAULT    = 8;
   localparam int KEY_BITS_DEFAULT = 32;

   localparam int SLOT_BITS     = 3;
   localparam int KEY_IN_BITS   = 32;
   localparam int KIND_BITS     = 2;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 4;
   localparam int ACTIVE_BITS   = 4;

   // waiter count carried through the queue; covers the largest slot table
   localparam int JOB_CNT_BITS = 7;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [0:0] CMD_REQUEST  = 1'b0;
   localparam logic [0:0] CMD_COMPLETE = 1'b1;

   localparam logic [KIND_BITS-1:0] KIND_ISSUE     = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_COALESCED = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_WAKE      = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ENABLE = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ACTIVE = 1'b1;

   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 4'd8;

   typedef struct packed {
      logic                   cmd;
      logic [SLOT_BITS-1:0]   slot;
      logic [KEY_IN_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] result_kind;
      logic [SLOT_BITS-1:0] target_slot;
      logic [SLOT_BITS-1:0] owner_slot;
      logic                 last;
   } rsp_type;

   // one queue entry: the first result and how many waiters follow it
   typedef struct packed {
      rsp_type                 rsp;
      logic [JOB_CNT_BITS-1:0] waiters;
   } job_type;

endpackage

FILE: rtl/icoal_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module icoal_ram #(
   parameter  int WIDTH = 3,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/icoal_fifo.sv
// Short queue of jobs between the classifying front and the result back end.
// Depends on icoal_pkg.
module icoal_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  icoal_pkg::job_type push_job,
   input  logic              pop,
   output icoal_pkg::job_type head_job,
   output logic              full,
   output logic              empty
);
   import icoal_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   job_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   fill_ff, fill_in;

   assign full     = (fill_ff == NW'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/icoal_front.sv
// Front end: accepts items, searches the slot table, updates it and queues
// one job per item. Writes the waiter memory. Depends on icoal_pkg.
module icoal_front #(
   parameter  int SLOTS    = icoal_pkg::SLOTS_DEFAULT,
   parameter  int KEY_BITS = icoal_pkg::KEY_BITS_DEFAULT,
   localparam int AW       = (SLOTS * SLOTS > 1) ? $clog2(SLOTS * SLOTS) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  icoal_pkg::req_type                 req_item,
   input  logic                               enable,
   input  logic [icoal_pkg::ACTIVE_BITS-1:0]  active_slots,
   input  logic                               drain_done,
   input  logic                               q_full,
   output logic                               push,
   output icoal_pkg::job_type                 push_job,
   output logic                               ram_we,
   output logic [AW-1:0]                      ram_waddr,
   output logic [icoal_pkg::SLOT_BITS-1:0]    ram_wdata
);
   import icoal_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int KW = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;

   req_type        item_ff;
   logic           valid_ff, valid_in;
   logic           drain_ff, drain_in;

   logic           slot_busy_ff [SLOTS];
   logic           slot_busy_in [SLOTS];
   logic [KW-1:0]  slot_key_ff  [SLOTS];
   logic [KW-1:0]  slot_key_in  [SLOTS];
   logic [CW-1:0]  count_ff     [SLOTS];
   logic [CW-1:0]  count_in     [SLOTS];

   logic [SLOTS-1:0]  match;
   logic              hit;
   logic [SW-1:0]     own;
   logic [SW-1:0]     s_idx;
   logic              in_range;
   logic              merge_on;
   logic [KW-1:0]     cmp_key;
   logic [CW-1:0]     own_count;
   logic [CW-1:0]     s_count;
   logic              accept;

   assign busy     = valid_ff || drain_ff;
   assign accept   = start && !busy;
   assign push     = valid_ff && !q_full;
   assign in_range = (int'(item_ff.slot) < SLOTS);
   assign s_idx    = SW'(item_ff.slot);
   assign merge_on = enable && in_range;
   assign cmp_key  = item_ff.key[KW-1:0];

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match[i] = slot_busy_ff[i] && (slot_key_ff[i] == cmp_key)
                    && (i < int'(active_slots));
      end
   end

   // lowest matching slot owns the request
   always_comb begin
      hit = 1'b0;
      own = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!hit && match[i]) begin
            hit = 1'b1;
            own = SW'(i);
         end
      end
   end

   assign own_count = count_ff[own];
   assign s_count   = count_ff[s_idx];

   always_comb begin
      push_job              = '0;
      push_job.rsp.target_slot = item_ff.slot;
      push_job.rsp.owner_slot  = item_ff.slot;
      push_job.rsp.last        = 1'b1;
      ram_we                = 1'b0;
      ram_waddr             = AW'(own) * AW'(SLOTS) + AW'(own_count);
      ram_wdata             = item_ff.slot;
      drain_in              = drain_ff && !drain_done;
      for (int i = 0; i < SLOTS; i++) begin
         slot_busy_in[i] = slot_busy_ff[i];
         slot_key_in[i]  = slot_key_ff[i];
         count_in[i]     = count_ff[i];
      end

      unique case (item_ff.cmd)
         CMD_REQUEST: begin
            push_job.rsp.result_kind = KIND_ISSUE;
            if (merge_on && hit) begin
               push_job.rsp.result_kind = KIND_COALESCED;
               push_job.rsp.owner_slot  = SLOT_BITS'(own);
               // append unless the list is full
               if (push && (int'(own_count) < SLOTS)) begin
                  ram_we        = 1'b1;
                  count_in[own] = own_count + CW'(1);
               end
            end else if (merge_on && push) begin
               slot_busy_in[s_idx] = 1'b1;
               slot_key_in[s_idx]  = cmp_key;
               count_in[s_idx]     = '0;
            end
         end
         CMD_COMPLETE: begin
            push_job.rsp.result_kind = KIND_WAKE;
            if (merge_on) begin
               push_job.waiters  = JOB_CNT_BITS'(s_count);
               push_job.rsp.last = (s_count == '0);
               if (push) begin
                  slot_busy_in[s_idx] = 1'b0;
                  count_in[s_idx]     = '0;
                  // hold new items off until the waiter list is read out
                  if (s_count != '0) begin
                     drain_in = 1'b1;
                  end
               end
            end
         end
         default: begin
            push_job.rsp.result_kind = KIND_ISSUE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         drain_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_busy_ff[i] <= 1'b0;
            count_ff[i]     <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         drain_ff <= drain_in;
         for (int i = 0; i < SLOTS; i++) begin
            slot_busy_ff[i] <= slot_busy_in[i];
            count_ff[i]     <= count_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      for (int i = 0; i < SLOTS; i++) begin
         slot_key_ff[i] <= slot_key_in[i];
      end
   end

endmodule

FILE: rtl/icoal_back.sv
// Back end: pops jobs, drives one result a cycle and reads waiter lists
// out of the waiter memory for completions. Depends on icoal_pkg.
module icoal_back #(
   parameter  int SLOTS = icoal_pkg::SLOTS_DEFAULT,
   localparam int AW    = (SLOTS * SLOTS > 1) ? $clog2(SLOTS * SLOTS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   output logic                            pop,
   input  icoal_pkg::job_type              q_job,
   output logic [AW-1:0]                   ram_raddr,
   input  logic [icoal_pkg::SLOT_BITS-1:0] ram_rdata,
   output logic                            drain_done,
   output logic                            rsp_valid,
   output icoal_pkg::rsp_type              rsp_item
);
   import icoal_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   logic                  active_ff, active_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         total_ff, total_in;
   logic [AW-1:0]         base_ff, base_in;
   logic [SLOT_BITS-1:0]  owner_ff, owner_in;
   logic                  rsp_valid_ff, emit;
   rsp_type               rsp_item_ff, emit_item;
   logic [AW-1:0]         job_base;
   logic [CW-1:0]         idx_next;

   assign job_base = AW'(SW'(q_job.rsp.owner_slot)) * AW'(SLOTS);
   assign idx_next = idx_ff + CW'(1);

   always_comb begin
      pop        = 1'b0;
      emit       = 1'b0;
      emit_item  = q_job.rsp;
      drain_done = 1'b0;
      active_in  = active_ff;
      idx_in     = idx_ff;
      total_in   = total_ff;
      base_in    = base_ff;
      owner_in   = owner_ff;
      ram_raddr  = base_ff + AW'(idx_next);
      if (active_ff) begin
         emit                  = 1'b1;
         emit_item.result_kind = KIND_WAKE;
         emit_item.target_slot = ram_rdata;
         emit_item.owner_slot  = owner_ff;
         emit_item.last        = (idx_next == total_ff);
         if (idx_next == total_ff) begin
            active_in  = 1'b0;
            drain_done = 1'b1;
         end else begin
            idx_in = idx_next;
         end
      end else if (!q_empty) begin
         pop  = 1'b1;
         emit = 1'b1;
         if (q_job.waiters != '0) begin
            // owner wake goes out now; start reading the first waiter
            active_in = 1'b1;
            idx_in    = '0;
            total_in  = CW'(q_job.waiters);
            base_in   = job_base;
            owner_in  = q_job.rsp.owner_slot;
            ram_raddr = job_base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      total_ff    <= total_in;
      base_ff     <= base_in;
      owner_ff    <= owner_in;
      rsp_item_ff <= emit_item;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

FILE: rtl/inflight_request_coalescer_core.sv
// Top level of the inflight request coalescer: register port, front end,
// job queue, back end and waiter memory. Depends on icoal_pkg and all rtl modules.
//
// Items are taken while busy is low. A new request, or a completion with no
// waiters, keeps the block busy until its job enters the queue; a completion
// whose owner has waiters keeps it busy until the waiter list is read out
// through the single read port of the waiter memory, which yields one waiter a
// cycle. Results leave in order, one per cycle, each marked by rsp_valid for
// one cycle; the receiver cannot stall them and nothing is held back. The first
// result of an item passes from the front end's item register through the job
// queue to the back end's output register. No clearing pass runs after reset.
module inflight_request_coalescer_core #(
   parameter int SLOTS    = icoal_pkg::SLOTS_DEFAULT,
   parameter int KEY_BITS = icoal_pkg::KEY_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  icoal_pkg::req_type                  req_item,
   output logic                                rsp_valid,
   output icoal_pkg::rsp_type                  rsp_item,
   input  logic                                csr_we,
   input  logic [icoal_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [icoal_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import icoal_pkg::*;

   localparam int AW = (SLOTS * SLOTS > 1) ? $clog2(SLOTS * SLOTS) : 1;

   logic                   enable_ff;
   logic [ACTIVE_BITS-1:0] active_ff;

   logic                   push, pop, q_full, q_empty, drain_done;
   job_type                push_job, head_job;
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr, ram_raddr;
   logic [SLOT_BITS-1:0]   ram_wdata, ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         active_ff <= ACTIVE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            CSR_ACTIVE: active_ff <= csr_wdata[ACTIVE_BITS-1:0];
            default:    active_ff <= active_ff;
         endcase
      end
   end

   icoal_front #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_item     (req_item),
      .enable       (enable_ff),
      .active_slots (active_ff),
      .drain_done   (drain_done),
      .q_full       (q_full),
      .push         (push),
      .push_job     (push_job),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata)
   );

   icoal_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   icoal_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (SLOTS * SLOTS)
   ) u_waiters (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   icoal_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .pop        (pop),
      .q_job      (head_job),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .drain_done (drain_done),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

endmodule
